// ----- src/htd_pkg.sv -----
package htd_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int ACC_W = 19;
	localparam int CODE_W = 31;
	localparam int LEN_W = 5;
	localparam int SYM_W = 16;
	localparam logic [LEN_W-1:0] GIVE_UP_LEN = LEN_W'(ACC_W);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;

	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DECODED = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [CODE_W-1:0] entry_code;
		logic [LEN_W-1:0] entry_length;
		logic [SYM_W-1:0] symbol_value;
		logic bit_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [SYM_W-1:0] symbol;
	} rsp_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0] len;
		logic [SYM_W-1:0] sym;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic [1:0] oq_cnt;
	} back_stat_t;

endpackage

// ----- src/htd_front.sv -----
module htd_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input htd_pkg::cmd_t cmd,
	output logic fq_empty,
	input logic fq_pop,
	output htd_pkg::cmd_t fq_head
);

	htd_pkg::cmd_t buf_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] cnt_q;
	logic wr;

	assign full = (cnt_q == 2'd2);
	assign fq_empty = (cnt_q == 2'd0);
	assign fq_head = buf_q[rptr_q];
	// unused op code is dropped here
	assign wr = push && !full && (cmd.op == htd_pkg::OP_ADD || cmd.op == htd_pkg::OP_CLEAR ||
		cmd.op == htd_pkg::OP_DECODE);

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wptr_q <= !wptr_q;
			if (fq_pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(fq_pop);
		end
	end

endmodule

// ----- src/htd_back.sv -----
module htd_back (
	input logic clk,
	input logic arst_n,
	input logic fq_empty,
	output logic fq_pop,
	input htd_pkg::cmd_t fq_head,
	output logic empty,
	input logic pop,
	output htd_pkg::rsp_t rsp,
	output htd_pkg::back_stat_t stat
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	htd_pkg::entry_t mem [htd_pkg::MAX_ENTRIES];
	htd_pkg::entry_t rd_q;
	logic [htd_pkg::CNT_W-1:0] count_q;
	logic [htd_pkg::CNT_W-1:0] idx_q;
	logic chk_s1;
	logic last_s1;
	logic [htd_pkg::ACC_W-1:0] acc_code_q;
	logic [htd_pkg::LEN_W-1:0] acc_len_q;
	logic [htd_pkg::ACC_W-1:0] acc_code_nx;
	logic [htd_pkg::LEN_W-1:0] acc_len_nx;

	htd_pkg::rsp_t oq_q [2];
	logic oq_w_q;
	logic oq_r_q;
	logic [1:0] oq_cnt_q;

	logic take;
	logic we;
	logic push_res;
	htd_pkg::rsp_t res;
	logic match;
	logic done;
	logic oq_pop;

	assign take = (state_q == ST_IDLE) && !fq_empty && (oq_cnt_q != 2'd2);
	assign fq_pop = take;
	assign acc_code_nx = {acc_code_q[htd_pkg::ACC_W-2:0], fq_head.bit_in};
	assign acc_len_nx = acc_len_q + htd_pkg::LEN_W'(1);
	assign match = chk_s1 && (rd_q.len == acc_len_q) &&
		(rd_q.code == htd_pkg::CODE_W'(acc_code_q));

	always_comb begin
		we = 1'b0;
		push_res = 1'b0;
		done = 1'b0;
		res = '0;
		if (take) begin
			unique case (fq_head.op)
				htd_pkg::OP_ADD: begin
					push_res = 1'b1;
					if (count_q < htd_pkg::CNT_W'(htd_pkg::MAX_ENTRIES)) begin
						we = 1'b1;
						res.status = htd_pkg::ST_ADDED;
					end else begin
						res.status = htd_pkg::ST_FULL;
					end
				end
				htd_pkg::OP_DECODE: begin
					if (count_q == '0 && acc_len_nx >= htd_pkg::GIVE_UP_LEN) begin
						push_res = 1'b1;
						res.status = htd_pkg::ST_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_SCAN) begin
			if (match) begin
				done = 1'b1;
				push_res = 1'b1;
				res.status = htd_pkg::ST_DECODED;
				res.symbol = rd_q.sym;
			end else if (chk_s1 && last_s1) begin
				done = 1'b1;
				if (acc_len_q >= htd_pkg::GIVE_UP_LEN) begin
					push_res = 1'b1;
					res.status = htd_pkg::ST_NOT_FOUND;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[count_q[htd_pkg::IDX_W-1:0]] <= '{code: fq_head.entry_code,
				len: fq_head.entry_length, sym: fq_head.symbol_value};
		end
		rd_q <= mem[idx_q[htd_pkg::IDX_W-1:0]];
		if (push_res) begin
			oq_q[oq_w_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			chk_s1 <= 1'b0;
			last_s1 <= 1'b0;
			acc_code_q <= '0;
			acc_len_q <= '0;
		end else if (take) begin
			unique case (fq_head.op)
				htd_pkg::OP_ADD: begin
					if (we) count_q <= count_q + htd_pkg::CNT_W'(1);
				end
				htd_pkg::OP_CLEAR: begin
					count_q <= '0;
				end
				htd_pkg::OP_DECODE: begin
					if (count_q == '0) begin
						if (push_res) begin
							acc_code_q <= '0;
							acc_len_q <= '0;
						end else begin
							acc_code_q <= acc_code_nx;
							acc_len_q <= acc_len_nx;
						end
					end else begin
						acc_code_q <= acc_code_nx;
						acc_len_q <= acc_len_nx;
						state_q <= ST_SCAN;
						idx_q <= '0;
						chk_s1 <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_SCAN) begin
			if (done) begin
				state_q <= ST_IDLE;
				chk_s1 <= 1'b0;
				if (push_res) begin
					acc_code_q <= '0;
					acc_len_q <= '0;
				end
			end else begin
				chk_s1 <= (idx_q < count_q);
				last_s1 <= (idx_q == count_q - htd_pkg::CNT_W'(1));
				if (idx_q < count_q) idx_q <= idx_q + htd_pkg::CNT_W'(1);
			end
		end
	end

	assign empty = (oq_cnt_q == 2'd0);
	assign rsp = oq_q[oq_r_q];
	assign oq_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_w_q <= 1'b0;
			oq_r_q <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (push_res) oq_w_q <= !oq_w_q;
			if (oq_pop) oq_r_q <= !oq_r_q;
			oq_cnt_q <= oq_cnt_q + 2'(push_res) - 2'(oq_pop);
		end
	end

	assign stat.busy = (state_q == ST_SCAN);
	assign stat.oq_cnt = oq_cnt_q;

endmodule

// ----- src/huffman_table_bit_decoder.sv -----
// Loadable Huffman code table (256 entries) with a bit-serial decoder. Add,
// clear and decode requests enter a two-deep queue; results leave through a
// two-deep queue. A decode request shifts one bit into the accumulated code
// and, if the table is not empty, scans the stored entries in add order
// through a single registered memory read port, one entry per cycle, and
// stops at the first exact (length, code) match.
module huffman_table_bit_decoder (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input htd_pkg::cmd_t cmd,
	output logic empty,
	input logic pop,
	output htd_pkg::rsp_t rsp
);

	logic fq_empty;
	logic fq_pop;
	htd_pkg::cmd_t fq_head;
	htd_pkg::back_stat_t stat;

	htd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.fq_empty(fq_empty),
		.fq_pop(fq_pop),
		.fq_head(fq_head)
	);

	htd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.fq_empty(fq_empty),
		.fq_pop(fq_pop),
		.fq_head(fq_head),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.stat(stat)
	);

`ifndef SYNTHESIS
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.oq_cnt != 2'd3) else $error("result queue overflow");
	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.status != htd_pkg::ST_DECODED |-> rsp.symbol == '0)
		else $error("nonzero symbol on non-decode result");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !fq_pop) else $error("request taken during scan");
`endif

endmodule
